FILE: rtl/pfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

  // widths
  localparam int PC_W   = 5;
  localparam int OP_W   = 4;
  localparam int COND_W = 4;
  localparam int IDX_W  = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_START_LEVEL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_LEVEL   = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTERVAL_MS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DURATION_MS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_USE_DURATION = 3'd5;

  // action codes
  localparam logic [1:0] ACT_POLL  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // pin modes
  localparam logic [1:0] PIN_PWM  = 2'd0;
  localparam logic [1:0] PIN_LOW  = 2'd1;
  localparam logic [1:0] PIN_HIGH = 2'd2;

  // fixed limits
  localparam logic [31:0] MIN_DURATION = 32'd500;
  localparam logic [31:0] MIN_INTERVAL = 32'd50;
  localparam logic [7:0]  LEVEL_MAX    = 8'd255;
  localparam logic [7:0]  HIGH_THRESH  = 8'd250;
  localparam logic [7:0]  LOW_THRESH   = 8'd10;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH       = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD_DIRECT = 4'd2;
  localparam logic [OP_W-1:0] OP_PREP        = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV_A       = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_IVL     = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_B       = 4'd6;
  localparam logic [OP_W-1:0] OP_SET_STEP    = 4'd7;
  localparam logic [OP_W-1:0] OP_START_END   = 4'd8;
  localparam logic [OP_W-1:0] OP_POLL_CMP    = 4'd9;
  localparam logic [OP_W-1:0] OP_POLL_UPD    = 4'd10;
  localparam logic [OP_W-1:0] OP_STOP        = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT        = 4'd12;

  // sequencer conditions
  localparam logic [COND_W-1:0] C_NEXT     = 4'd0;
  localparam logic [COND_W-1:0] C_GOTO     = 4'd1;
  localparam logic [COND_W-1:0] C_IN       = 4'd2;
  localparam logic [COND_W-1:0] C_IF_START = 4'd3;
  localparam logic [COND_W-1:0] C_IF_STOP  = 4'd4;
  localparam logic [COND_W-1:0] C_IF_POLL  = 4'd5;
  localparam logic [COND_W-1:0] C_IF_DUR   = 4'd6;
  localparam logic [COND_W-1:0] C_DIVWAIT  = 4'd7;
  localparam logic [COND_W-1:0] C_IF_QBIG  = 4'd8;
  localparam logic [COND_W-1:0] C_OUTWAIT  = 4'd9;

  // program labels
  localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] PC_START     = 5'd5;
  localparam logic [PC_W-1:0] PC_DUR       = 5'd7;
  localparam logic [PC_W-1:0] PC_START_END = 5'd14;
  localparam logic [PC_W-1:0] PC_POLL      = 5'd15;
  localparam logic [PC_W-1:0] PC_STOP      = 5'd17;
  localparam logic [PC_W-1:0] PC_EMIT      = 5'd18;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic [OP_W-1:0]   op;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fire;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic [1:0] action;
    logic       use_dur;
    logic       div_busy;
    logic       q_big;
    logic       out_hold;
  } stat_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    uw = '{cond: C_GOTO, target: PC_IDLE, op: OP_NOP};
    case (pc)
      5'd0:  uw = '{cond: C_IN,       target: 5'd1,         op: OP_LATCH};
      5'd1:  uw = '{cond: C_IF_START, target: PC_START,     op: OP_NOP};
      5'd2:  uw = '{cond: C_IF_STOP,  target: PC_STOP,      op: OP_NOP};
      5'd3:  uw = '{cond: C_IF_POLL,  target: PC_POLL,      op: OP_NOP};
      5'd4:  uw = '{cond: C_GOTO,     target: PC_EMIT,      op: OP_NOP};
      5'd5:  uw = '{cond: C_IF_DUR,   target: PC_DUR,       op: OP_NOP};
      5'd6:  uw = '{cond: C_GOTO,     target: PC_START_END, op: OP_LOAD_DIRECT};
      5'd7:  uw = '{cond: C_NEXT,     target: PC_IDLE,      op: OP_PREP};
      5'd8:  uw = '{cond: C_NEXT,     target: PC_IDLE,      op: OP_DIV_A};
      5'd9:  uw = '{cond: C_DIVWAIT,  target: PC_IDLE,      op: OP_NOP};
      5'd10: uw = '{cond: C_IF_QBIG,  target: PC_START_END, op: OP_SET_IVL};
      5'd11: uw = '{cond: C_NEXT,     target: PC_IDLE,      op: OP_DIV_B};
      5'd12: uw = '{cond: C_DIVWAIT,  target: PC_IDLE,      op: OP_NOP};
      5'd13: uw = '{cond: C_NEXT,     target: PC_IDLE,      op: OP_SET_STEP};
      5'd14: uw = '{cond: C_GOTO,     target: PC_EMIT,      op: OP_START_END};
      5'd15: uw = '{cond: C_NEXT,     target: PC_IDLE,      op: OP_POLL_CMP};
      5'd16: uw = '{cond: C_GOTO,     target: PC_EMIT,      op: OP_POLL_UPD};
      5'd17: uw = '{cond: C_NEXT,     target: PC_IDLE,      op: OP_STOP};
      5'd18: uw = '{cond: C_OUTWAIT,  target: PC_IDLE,      op: OP_EMIT};
      default: uw = '{cond: C_GOTO, target: PC_IDLE, op: OP_NOP};
    endcase
    return uw;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pfr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quot
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic [32:0] trial;
  logic [32:0] diff;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quot[31]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem  <= diff[31:0];
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem  <= trial[31:0];
        quot <= {quot[30:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pfr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_seq
  import pfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire stat_t stat,
  output logic       in_ready,
  output ctrl_t      ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [PC_W-1:0] pc_inc;
  logic            stall;
  ucode_t          uw;

  assign uw     = ucode_rom(pc);
  assign pc_inc = pc + 5'd1;

  // next step and stall decision
  always_comb begin
    stall   = 1'b0;
    pc_next = pc_inc;
    case (uw.cond)
      C_NEXT:     pc_next = pc_inc;
      C_GOTO:     pc_next = uw.target;
      C_IN: begin
        stall   = !in_valid;
        pc_next = uw.target;
      end
      C_IF_START: pc_next = (stat.action == ACT_START) ? uw.target : pc_inc;
      C_IF_STOP:  pc_next = (stat.action == ACT_STOP) ? uw.target : pc_inc;
      C_IF_POLL:  pc_next = (stat.action == ACT_POLL) ? uw.target : pc_inc;
      C_IF_DUR:   pc_next = stat.use_dur ? uw.target : pc_inc;
      C_DIVWAIT:  stall = stat.div_busy;
      C_IF_QBIG:  pc_next = stat.q_big ? uw.target : pc_inc;
      C_OUTWAIT: begin
        stall   = stat.out_hold;
        pc_next = uw.target;
      end
      default:    pc_next = PC_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else if (!stall) begin
      pc <= pc_next;
    end
  end

  assign in_ready  = (pc == PC_IDLE);
  assign ctrl.op   = uw.op;
  assign ctrl.fire = !stall;

endmodule
`default_nettype wire

FILE: rtl/pfr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_dp
  import pfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctrl_t            ctrl,
  output stat_t                 stat,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  wire logic [1:0]       action,
  input  wire logic [31:0]      now_ms,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            pwm_level,
  output logic                  ramp_active,
  output logic [1:0]            pin_mode,
  output logic                  level_updated
);

  // configuration
  logic [7:0]  start_level;
  logic [8:0]  step_size;
  logic [31:0] interval_ms;
  logic [31:0] duration_ms;
  logic        use_duration;

  // ramp state
  logic [7:0]  level;
  logic        active;
  logic [31:0] last_change;
  logic [7:0]  target;
  logic [8:0]  eff_step;
  logic [31:0] eff_interval;

  // per-word working registers
  logic [1:0]  action_q;
  logic [31:0] now_q;
  logic        updated;
  logic        hit;
  logic [7:0]  diff;
  logic        neg;
  logic [31:0] dur_eff;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_busy;
  logic [31:0] quot;
  logic [13:0] diff50;
  logic [8:0]  mag;
  logic [31:0] elapsed;
  logic [9:0]  sum;
  logic        at_end;
  logic [7:0]  sat_level;
  logic        do_op;
  logic [1:0]  mode;
  logic        emit_now;

  assign do_op    = ctrl.fire;
  assign emit_now = do_op && (ctrl.op == OP_EMIT);

  // shared divider: interval first, then step magnitude
  assign diff50       = ({6'd0, diff} << 5) + ({6'd0, diff} << 4) + ({6'd0, diff} << 1);
  assign div_start    = do_op && ((ctrl.op == OP_DIV_A) || (ctrl.op == OP_DIV_B));
  assign div_dividend = (ctrl.op == OP_DIV_A) ? dur_eff : {18'd0, diff50};
  assign div_divisor  = (ctrl.op == OP_DIV_A) ? {24'd0, diff} : dur_eff;

  pfr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign mag = (quot == 32'd0) ? 9'd1 : quot[8:0];

  // poll arithmetic
  assign elapsed = now_q - last_change;
  assign sum     = {2'b00, level} + {eff_step[8], eff_step};
  assign at_end  = (!eff_step[8] && (eff_step != 9'd0) && (level >= target)) ||
                   (eff_step[8] && (level <= target));

  always_comb begin
    if (sum[9]) begin
      sat_level = 8'd0;
    end else if (sum[8]) begin
      sat_level = LEVEL_MAX;
    end else begin
      sat_level = sum[7:0];
    end
  end

  // pin mode from current state
  always_comb begin
    mode = PIN_PWM;
    if (!active) begin
      if (level < LOW_THRESH) begin
        mode = PIN_LOW;
      end else if (level >= HIGH_THRESH) begin
        mode = PIN_HIGH;
      end
    end
  end

  // registers and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      start_level  <= 8'd0;
      step_size    <= 9'd1;
      interval_ms  <= MIN_INTERVAL;
      duration_ms  <= MIN_DURATION;
      use_duration <= 1'b0;
      level        <= 8'd0;
      active       <= 1'b0;
      last_change  <= 32'd0;
      target       <= 8'd0;
      eff_step     <= 9'd1;
      eff_interval <= MIN_INTERVAL;
      updated      <= 1'b0;
      hit          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_LEVEL:  start_level  <= cfg_data[7:0];
          REG_STOP_LEVEL:   target       <= cfg_data[7:0];
          REG_STEP_SIZE:    step_size    <= cfg_data[8:0];
          REG_INTERVAL_MS:  interval_ms  <= cfg_data;
          REG_DURATION_MS:  duration_ms  <= cfg_data;
          REG_USE_DURATION: use_duration <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && !emit_now) begin
        out_valid <= 1'b0;
      end

      if (do_op) begin
        case (ctrl.op)
          OP_LATCH: begin
            action_q <= action;
            now_q    <= now_ms;
            updated  <= 1'b0;
          end
          OP_LOAD_DIRECT: begin
            eff_step     <= step_size;
            eff_interval <= interval_ms;
          end
          OP_PREP: begin
            if (start_level > target) begin
              diff <= start_level - target;
              neg  <= 1'b1;
            end else if (target > start_level) begin
              diff <= target - start_level;
              neg  <= 1'b0;
            end else begin
              diff <= 8'd1;
              neg  <= 1'b0;
            end
            dur_eff <= (duration_ms < MIN_DURATION) ? MIN_DURATION : duration_ms;
          end
          OP_SET_IVL: begin
            eff_interval <= stat.q_big ? quot : MIN_INTERVAL;
            eff_step     <= neg ? 9'h1FF : 9'd1;
          end
          OP_SET_STEP: begin
            eff_step <= neg ? (9'd0 - mag) : mag;
          end
          OP_START_END: begin
            level  <= start_level;
            active <= 1'b1;
          end
          OP_POLL_CMP: begin
            hit <= active && (elapsed >= eff_interval);
          end
          OP_POLL_UPD: begin
            if (hit) begin
              last_change <= now_q;
              updated     <= 1'b1;
              if (at_end) begin
                level  <= target;
                active <= 1'b0;
              end else begin
                level <= sat_level;
              end
            end
          end
          OP_STOP: begin
            active  <= 1'b0;
            target  <= 8'd0;
            level   <= 8'd0;
            updated <= 1'b1;
          end
          OP_EMIT: begin
            out_valid     <= 1'b1;
            pwm_level     <= level;
            ramp_active   <= active;
            pin_mode      <= mode;
            level_updated <= updated;
          end
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready     = 1'b1;
  assign stat.action   = action_q;
  assign stat.use_dur  = use_duration;
  assign stat.div_busy = div_busy;
  assign stat.q_big    = (quot >= MIN_INTERVAL);
  assign stat.out_hold = out_valid && !out_ready;

endmodule
`default_nettype wire

FILE: rtl/pwm_fade_ramp.sv
// channel | direction | payload                                   | handshake
// cfg     | in        | cfg_index, cfg_data                       | cfg_valid / cfg_ready
// in      | in        | action, now_ms                            | in_valid / in_ready
// out     | out       | pwm_level, ramp_active, pin_mode,         | out_valid / out_ready
//         |           | level_updated                             |
//
// One word at a time; the microcode step counter sets the latency.
// Start in duration mode runs the serial divider once, or twice when the interval
// is clamped and the step size is divided out as well.
// Synchronous reset returns config and ramp state to defaults; cfg is always ready.
// A stalled result holds in the output register; the next word is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module pwm_fade_ramp
  import pfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       action,
  input  wire logic [31:0]      now_ms,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            pwm_level,
  output logic                  ramp_active,
  output logic [1:0]            pin_mode,
  output logic                  level_updated
);

  ctrl_t ctrl;
  stat_t stat;

  // microcode sequencer
  pfr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // datapath with registers and divider
  pfr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pwm_level     (pwm_level),
    .ramp_active   (ramp_active),
    .pin_mode      (pin_mode),
    .level_updated (level_updated)
  );

endmodule
`default_nettype wire

FILE: rtl/pfr_check.sv
`timescale 1ns / 1ps
`default_nettype none
module pfr_check
  import pfr_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       pwm_level,
  input wire logic             ramp_active,
  input wire logic [1:0]       pin_mode,
  input wire logic             level_updated
);

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one word in flight: input closes after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pwm_level) &&
      $stable(ramp_active) && $stable(pin_mode) && $stable(level_updated)))
    else $error("stalled result changed");

  // a running ramp always drives pwm
  a_active_pwm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ramp_active) |-> (pin_mode == PIN_PWM))
    else $error("pin forced while ramp active");

  // forced low only for a low level
  a_low_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pin_mode == PIN_LOW)) |-> (pwm_level < LOW_THRESH))
    else $error("forced low at high level");

endmodule

bind pwm_fade_ramp pfr_check u_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pwm_level     (pwm_level),
  .ramp_active   (ramp_active),
  .pin_mode      (pin_mode),
  .level_updated (level_updated)
);
`default_nettype wire
